[hw/rtl/utf8_to_ucs2_decoder_assert.svh]
// Assertion macros shared by the checker of the UTF-8 to UCS-2 decoder.
`ifndef UTF8_TO_UCS2_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define U8D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that stays live through reset.
`define U8D_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/u8d_pkg.sv]
// Package with the shared types and constants of the UTF-8 to UCS-2 decoder.
`timescale 1ns / 1ps

package u8d_pkg;

  // Result queue sizing: two results at most per input item.
  localparam int MAX_RES_PER_ITEM = 2;
  localparam int QUEUE_DEPTH      = 8;
  localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW         = $clog2(QUEUE_DEPTH + 1);
  // Highest fill that still leaves room for a stage item and a new item.
  localparam int READY_LIMIT      = QUEUE_DEPTH - MAX_RES_PER_ITEM;

  // Register map, counted in 32-bit words.
  localparam logic REG_MAX_UNITS = 1'b0;
  localparam logic [15:0] MAX_UNITS_RESET = 16'hFFFF;

  // Lead byte patterns.
  localparam logic [2:0] LEAD2_PAT = 3'b110;
  localparam logic [3:0] LEAD3_PAT = 4'hE;

  typedef struct packed {
    logic        end_res;
    logic [15:0] code_unit;
  } res_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } item_t;

  // Results that one decoded item pushes into the queue, first one first.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } wr_t;

  typedef struct packed {
    logic [QUEUE_CW-1:0] count;
  } q_stat_t;

endpackage

[hw/rtl/u8d_decode.sv]
// Input register and per-byte decoding with the sequence state.
`timescale 1ns / 1ps

module u8d_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  u8d_pkg::item_t item,
  input  logic [15:0]   max_units,
  output logic          stage_valid,
  output u8d_pkg::wr_t  wr
);
  import u8d_pkg::*;

  typedef enum logic [1:0] {PEND_NONE, PEND_ONE, PEND_TWO} pend_t;

  logic        s_v_r;
  item_t       s_item_r;
  pend_t       pend_r, pend_nxt;
  logic [9:0]  partial_r, partial_nxt;
  logic [15:0] units_r, units_nxt;
  logic        unit_v;
  logic [15:0] unit_code;
  logic [7:0]  b;

  assign b = s_item_r.in_byte;

  always_comb begin
    pend_nxt    = pend_r;
    partial_nxt = partial_r;
    units_nxt   = units_r;
    unit_v      = 1'b0;
    unit_code   = '0;
    if (s_v_r) begin
      if (units_r < max_units) begin
        case (pend_r)
          PEND_TWO: begin
            partial_nxt = {partial_r[3:0], b[5:0]};
            pend_nxt    = PEND_ONE;
          end
          PEND_ONE: begin
            unit_v      = 1'b1;
            unit_code   = {partial_r, b[5:0]};
            partial_nxt = '0;
            pend_nxt    = PEND_NONE;
            units_nxt   = units_r + 16'd1;
          end
          default: begin
            if (!b[7]) begin
              unit_v    = 1'b1;
              unit_code = {8'h00, b};
              units_nxt = units_r + 16'd1;
            end else if (b[7:5] == LEAD2_PAT) begin
              partial_nxt = {5'b0, b[4:0]};
              pend_nxt    = PEND_ONE;
            end else if (b[7:4] == LEAD3_PAT) begin
              partial_nxt = {6'b0, b[3:0]};
              pend_nxt    = PEND_TWO;
            end
            // Stray continuations and F0-FF leave the state as it is.
          end
        endcase
      end
      if (s_item_r.last) begin
        pend_nxt    = PEND_NONE;
        partial_nxt = '0;
        units_nxt   = '0;
      end
    end
  end

  always_comb begin
    wr.cnt    = {1'b0, s_v_r & unit_v} + {1'b0, s_v_r & s_item_r.last};
    wr.first  = unit_v ? res_t'{end_res: 1'b0, code_unit: unit_code}
                       : res_t'{end_res: 1'b1, code_unit: 16'h0000};
    wr.second = res_t'{end_res: 1'b1, code_unit: 16'h0000};
  end

  assign stage_valid = s_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r     <= 1'b0;
      pend_r    <= PEND_NONE;
      partial_r <= '0;
      units_r   <= '0;
    end else begin
      s_v_r     <= accept;
      pend_r    <= pend_nxt;
      partial_r <= partial_nxt;
      units_r   <= units_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_item_r <= item;
    end
  end

endmodule

[hw/rtl/u8d_outq.sv]
// Result queue that takes up to two results per cycle and hands out one.
`timescale 1ns / 1ps

module u8d_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  u8d_pkg::wr_t     wr,
  input  logic             pop_ready,
  output logic             pop_valid,
  output u8d_pkg::res_t    pop_data,
  output u8d_pkg::q_stat_t stat
);
  import u8d_pkg::*;

  res_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  logic [QUEUE_AW-1:0] wr_ptr_p1;
  logic                pop;

  assign wr_ptr_p1 = wr_ptr_r + {{(QUEUE_AW-1){1'b0}}, 1'b1};
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];
  assign pop       = pop_valid & pop_ready;
  assign stat.count = count_r;

  assign count_nxt = count_r + {{(QUEUE_CW-2){1'b0}}, wr.cnt}
                   - {{(QUEUE_CW-1){1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + {{(QUEUE_AW-2){1'b0}}, wr.cnt};
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + {{(QUEUE_AW-1){1'b0}}, 1'b1};
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) begin
      mem[wr_ptr_r] <= wr.first;
    end
    if (wr.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= wr.second;
    end
  end

endmodule

[hw/rtl/utf8_to_ucs2_decoder.sv]
// Flow: an accepted byte is decoded from the stage register and its results are written
// into the result queue. Throughput: one byte per cycle unless the input stalls; a last
// byte yields up to two results, drained one a cycle while out_tready is high.
// Input stalls when the eight-entry result queue holds more than four results while a
// byte is in decode, or more than six otherwise. Reset (rst_n low, synchronous) empties
// the queue, clears the sequence state and sets max_units to 65535.
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream: one UTF-8 byte per item.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // last byte of the stream
  // Result stream: one UCS-2 code unit per item.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_unit
  output logic        out_tlast,  // end_res: set only on the zero terminator
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import u8d_pkg::*;

  logic [15:0] max_units_r;
  logic        accept;
  logic        stage_valid;
  item_t       item;
  wr_t         wr;
  res_t        res;
  q_stat_t     qstat;
  logic [QUEUE_CW-1:0] fill_bound;

  // The register file holds one word; the upper address bit selects the word and
  // addresses beyond it are ignored on write and read back as zero.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_UNITS) ? {16'h0000, max_units_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_units_r <= MAX_UNITS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == REG_MAX_UNITS) begin
      max_units_r <= cfg_pwdata[15:0];
    end
  end

  // A new byte is taken only when the queue can absorb both the results of the
  // byte now being decoded and those of the new one, whatever the output does.
  // The bound is built from registered values only, so in_tready never depends
  // combinationally on out_tready.
  assign fill_bound = qstat.count
                    + (stage_valid ? QUEUE_CW'(MAX_RES_PER_ITEM) : '0);
  assign in_tready  = (fill_bound <= QUEUE_CW'(READY_LIMIT));
  assign accept     = in_tvalid & in_tready;

  assign item.in_byte = in_tdata;
  assign item.last    = in_tlast;

  u8d_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (item),
    .max_units   (max_units_r),
    .stage_valid (stage_valid),
    .wr          (wr)
  );

  u8d_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .pop_ready (out_tready),
    .pop_valid (out_tvalid),
    .pop_data  (res),
    .stat      (qstat)
  );

  assign out_tdata = res.code_unit;
  assign out_tlast = res.end_res;

endmodule

[hw/rtl/u8d_checker.sv]
// Port-level checker for the UTF-8 to UCS-2 decoder and its bind.
`timescale 1ns / 1ps
`include "utf8_to_ucs2_decoder_assert.svh"

module u8d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [2:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  // A stalled result must hold.
  `U8D_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // The terminator always carries a zero code unit.
  `U8D_ASSERT_NOW(a_term_zero, out_tvalid && out_tlast, out_tdata == 16'h0000, "terminator with non-zero data")

  // Reset leaves the queue empty.
  `U8D_ASSERT_RST(a_rst_empty, !rst_n, !out_tvalid, "result pending after reset")

  // Reset leaves the block ready for a new byte.
  `U8D_ASSERT_RST(a_rst_ready, !rst_n, in_tready, "input not ready after reset")

endmodule

bind utf8_to_ucs2_decoder u8d_checker u_chk (.*);

[tb/utf8_to_ucs2_decoder_checker.sv]
// Checker for the UTF-8 to UCS-2 decoder: watches the streams, predicts results and compares.
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder_checker
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // last byte of the stream
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [15:0] code_unit
  input  logic        out_tlast,  // end_res
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int unsigned fail_count,
  output int unsigned units_due
);

  localparam logic [2:0] ADDR_MAX_UNITS = {REG_MAX_UNITS, 2'b00};
  localparam logic [1:0] CONT_PAT       = 2'b10;

  // Shadow of the decoder state and its register.
  logic [15:0] unit_limit = MAX_UNITS_RESET;
  logic [1:0]  cont_left  = '0;
  logic [9:0]  payload    = '0;
  logic [15:0] units_out  = '0;
  res_t        unit_fifo[$];

  int unsigned errors  = 0;
  int unsigned due_cnt = 0;

  assign fail_count = errors;
  assign units_due  = due_cnt;

  task automatic take_byte(input logic [7:0] b, input logic is_last);
    res_t r;
    r = '0;
    if (units_out < unit_limit) begin
      if (cont_left == 2'd2) begin
        payload   = {payload[3:0], b[5:0]};
        cont_left = 2'd1;
      end else if (cont_left == 2'd1) begin
        // Any byte at all closes the sequence, only its low six bits count.
        r.code_unit = {payload, b[5:0]};
        unit_fifo.push_back(r);
        payload   = '0;
        cont_left = '0;
        units_out = units_out + 16'd1;
      end else if (!b[7]) begin
        r.code_unit = {8'h00, b};
        unit_fifo.push_back(r);
        units_out = units_out + 16'd1;
      end else if (b[7:6] == CONT_PAT) begin
        // A stray continuation byte is dropped.
        cont_left = '0;
      end else if (b[7:5] == LEAD2_PAT) begin
        payload   = {5'd0, b[4:0]};
        cont_left = 2'd1;
      end else if (b[7:4] == LEAD3_PAT) begin
        payload   = {6'd0, b[3:0]};
        cont_left = 2'd2;
      end
    end
    if (is_last) begin
      r.code_unit = '0;
      r.end_res   = 1'b1;
      unit_fifo.push_back(r);
      payload   = '0;
      cont_left = '0;
      units_out = '0;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      unit_limit = MAX_UNITS_RESET;
      cont_left  = '0;
      payload    = '0;
      units_out  = '0;
      unit_fifo.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (unit_fifo.size() == 0) begin
          $error("unexpected result: code_unit %h end_res %b", out_tdata, out_tlast);
          errors++;
        end else begin
          want = unit_fifo.pop_front();
          if (out_tdata !== want.code_unit) begin
            $error("code_unit: expected %h, got %h", want.code_unit, out_tdata);
            errors++;
          end
          if (out_tlast !== want.end_res) begin
            $error("end_res: expected %b, got %b", want.end_res, out_tlast);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready)
        take_byte(in_tdata, in_tlast);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ADDR_MAX_UNITS)
        unit_limit = cfg_pwdata[15:0];
    end
    due_cnt = unit_fifo.size();
  end

endmodule

[tb/tb_utf8_to_ucs2_decoder.sv]
// Top of the testbench for the UTF-8 to UCS-2 decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_utf8_to_ucs2_decoder;
  import u8d_pkg::*;

  localparam logic [2:0] ADDR_MAX_UNITS = {REG_MAX_UNITS, 2'b00};
  localparam logic [1:0] CONT_PAT       = 2'b10;
  // Cycles without any accepted item before the run is declared hung. The slowest
  // correct stretch is a receiver stall, for which this is ample.
  localparam int STALL_LIMIT = 2000;
  // The decoder holds a byte in its stage register before the queue; let it drain before a write.
  localparam int SETTLE_CYCLES = 4;

  // Directed bytes, bit 8 being the last flag. They cover the ASCII extremes, the
  // smallest and largest two- and three-byte sequences, stray continuations, the
  // lead bytes of four-byte forms, ASCII and lead bytes consumed as continuations,
  // a last byte that completes a sequence, one that cuts a sequence short, and a
  // plain ASCII last byte.
  localparam logic [8:0] BASIC_SEQ [26] = '{
    9'h000, 9'h07F, 9'h0C0, 9'h080, 9'h0DF, 9'h0BF, 9'h0E0, 9'h080, 9'h080,
    9'h0EF, 9'h0BF, 9'h0BF, 9'h080, 9'h0BF, 9'h0F0, 9'h0FF, 9'h0C3, 9'h041,
    9'h0E2, 9'h0C3, 9'h0FF, 9'h0C3, 9'h1A9, 9'h0E2, 9'h182, 9'h141
  };
  // Run with a limit of one unit: everything after the first unit is ignored,
  // yet the terminator still comes.
  localparam logic [8:0] LIMIT_SEQ [4] = '{9'h041, 9'h042, 9'h0E2, 9'h143};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int unsigned fail_count;
  int unsigned units_due;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;

  always #4 clk = ~clk;

  utf8_to_ucs2_decoder u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  utf8_to_ucs2_decoder_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .units_due   (units_due)
  );

  // The receiver decides afresh at every falling edge whether it takes a result.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a run in which no item moves on either side for too long has hung.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one byte and returns at the falling edge after it was accepted. The
  // caller is always at a falling edge, so valid is only ever lowered in a gap
  // and never lowered and raised within one time step.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct)
      gap = $urandom_range(4, 1);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Holds the sender back until every expected unit has arrived and the
  // pipeline has had time to empty, even of bytes that cause no unit.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (units_due != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: a setup phase, then the access phase.
  task automatic write_max_units(input logic [15:0] value);
    settle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_MAX_UNITS;
    cfg_pwdata  <= {16'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // One stream of random symbols, last flag on its final byte. Most symbols are
  // well-formed characters of one, two or three bytes with random payload; the
  // rest are arbitrary bytes, which break sequences and bring in stray bytes.
  task automatic send_random_stream(input int max_syms, inout int sent);
    logic [7:0] stream_q[$];
    int         n_sym;
    int         pick;
    n_sym = $urandom_range(max_syms, 1);
    for (int s = 0; s < n_sym; s++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        stream_q.push_back(8'($urandom_range(127)));
      end else if (pick < 55) begin
        stream_q.push_back({LEAD2_PAT, 5'($urandom)});
        stream_q.push_back({CONT_PAT, 6'($urandom)});
      end else if (pick < 80) begin
        stream_q.push_back({LEAD3_PAT, 4'($urandom)});
        stream_q.push_back({CONT_PAT, 6'($urandom)});
        stream_q.push_back({CONT_PAT, 6'($urandom)});
      end else begin
        stream_q.push_back(8'($urandom));
      end
    end
    foreach (stream_q[i])
      send_byte(stream_q[i], i == stream_q.size() - 1);
    sent += stream_q.size();
  endtask

  // Random streams until the byte budget is spent, optionally with one pause
  // half-way in which the sender waits for every expected unit.
  task automatic random_part(input int budget, input int max_syms, input bit mid_pause);
    int sent;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < budget) begin
      if (mid_pause && !paused && sent >= budget / 2) begin
        settle();
        paused = 1'b1;
      end
      send_random_stream(max_syms, sent);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First setting: the reset limit of 65535; sender idles lightly, receiver often.
    send_idle_pct = 18;
    recv_idle_pct = 54;
    foreach (BASIC_SEQ[i])
      send_byte(BASIC_SEQ[i][7:0], BASIC_SEQ[i][8]);
    random_part(150, 12, 1'b0);

    // A limit of one: one unit per stream, short streams so that it resets often.
    write_max_units(16'd1);
    foreach (LIMIT_SEQ[i])
      send_byte(LIMIT_SEQ[i][7:0], LIMIT_SEQ[i][8]);
    random_part(60, 3, 1'b0);

    // A small limit that streams reach now and then; the idling swaps sides.
    write_max_units(16'($urandom_range(8, 2)));
    send_idle_pct = 54;
    recv_idle_pct = 18;
    random_part(100, 8, 1'b0);

    write_max_units(16'($urandom_range(65534, 9)));
    random_part(170, 12, 1'b1);

    // Largest limit again, with neither side idling.
    write_max_units(16'hFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_part(170, 12, 1'b0);

    // Wait for the last units, then a little longer for anything unexpected.
    settle();
    repeat (16) @(negedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_decode.sv
hw/rtl/u8d_outq.sv
hw/rtl/utf8_to_ucs2_decoder.sv
hw/rtl/u8d_checker.sv
tb/utf8_to_ucs2_decoder_checker.sv
tb/tb_utf8_to_ucs2_decoder.sv
